### rtl/csm_pkg.sv
`timescale 1ns / 1ps

package csm_pkg;

    // Store geometry and result limit
    localparam int STORE_DEPTH = 1024;
    localparam int MAX_MATCHES = 16;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int PTR_W       = ADDR_W + 1;
    localparam int CNT_W       = $clog2(MAX_MATCHES + 1);
    localparam int OFFSET_W    = 10;

    // Store byte codes
    localparam logic [7:0] MARK_ANY   = 8'd255;
    localparam logic [7:0] MARK_LIST  = 8'd254;
    localparam logic [7:0] MARK_RANGE = 8'd253;
    localparam logic [7:0] MARK_END   = 8'd252;
    localparam logic [7:0] CMD_END    = 8'd0;

    // Request kinds
    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_TICK  = 1'b1;

    // Time field slots
    localparam logic [2:0] FLD_MINUTE  = 3'd0;
    localparam logic [2:0] FLD_HOUR    = 3'd1;
    localparam logic [2:0] FLD_DAY     = 3'd2;
    localparam logic [2:0] FLD_MONTH   = 3'd3;
    localparam logic [2:0] FLD_WEEKDAY = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_EVAL,
        ST_RECORD,
        ST_FLUSH
    } csm_state_t;

    typedef enum logic [2:0] {
        PH_ENTRY,
        PH_HEAD,
        PH_LIST,
        PH_LIST_SKIP,
        PH_RANGE_LO,
        PH_RANGE_HI,
        PH_CMD
    } csm_phase_t;

    typedef struct packed {
        logic       action;
        logic [9:0] store_addr;
        logic [7:0] store_byte;
        logic [5:0] minute;
        logic [4:0] hour;
        logic [4:0] day_of_month;
        logic [3:0] month;
        logic [2:0] weekday;
    } csm_in_t;

    typedef struct packed {
        logic [OFFSET_W-1:0] command_offset;
        logic                matched;
        logic                overflow;
        logic                last;
    } csm_out_t;

    typedef struct packed {
        logic eq;
        logic gt;
        logic lt;
    } csm_cmp_t;

    typedef struct packed {
        logic     valid;
        csm_out_t data;
    } csm_push_t;

endpackage

### rtl/csm_store.sv
`timescale 1ns / 1ps

module csm_store (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [csm_pkg::ADDR_W-1:0] wr_addr,
    input  logic [7:0]               wr_data,
    input  logic                     rd_en,
    input  logic [csm_pkg::ADDR_W-1:0] rd_addr,
    output logic [7:0]               rd_data
);

    logic [7:0] mem [csm_pkg::STORE_DEPTH];
    logic [7:0] rd_data_reg;

    // Write one byte per request
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/csm_cmp.sv
`timescale 1ns / 1ps

module csm_cmp (
    input  logic [7:0]        a,
    input  logic [7:0]        b,
    output csm_pkg::csm_cmp_t res
);

    // Shared magnitude compare of a store byte against a time value
    always_comb begin
        res.eq = (a == b);
        res.gt = (a > b);
        res.lt = (a < b);
    end

endmodule

### rtl/csm_seq.sv
`timescale 1ns / 1ps

module csm_seq (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  csm_pkg::csm_in_t           tick,
    output logic                       busy,
    output logic                       rd_en,
    output logic [csm_pkg::ADDR_W-1:0] rd_addr,
    input  logic [7:0]                 rd_data,
    input  logic                       out_free,
    output csm_pkg::csm_push_t         push
);

    csm_pkg::csm_state_t state_reg, state_next;
    csm_pkg::csm_phase_t phase_reg, phase_next;
    logic [csm_pkg::PTR_W-1:0]    ptr_reg, ptr_next;
    logic [2:0]                   fidx_reg, fidx_next;
    logic                         mismatch_reg, mismatch_next;
    logic [csm_pkg::CNT_W-1:0]    count_reg, count_next;
    logic                         dropped_reg, dropped_next;
    logic                         pend_valid_reg, pend_valid_next;
    logic [csm_pkg::OFFSET_W-1:0] pend_off_reg, pend_off_next;
    logic [5:0]                   minute_reg, minute_next;
    logic [4:0]                   hour_reg, hour_next;
    logic [4:0]                   day_reg, day_next;
    logic [3:0]                   month_reg, month_next;
    logic [2:0]                   wday_reg, wday_next;

    logic [7:0]                   cur_value;
    csm_pkg::csm_cmp_t            cmp;

    // Pick the time value for the field under test
    always_comb begin
        case (fidx_reg)
            csm_pkg::FLD_MINUTE:  cur_value = 8'(minute_reg);
            csm_pkg::FLD_HOUR:    cur_value = 8'(hour_reg);
            csm_pkg::FLD_DAY:     cur_value = 8'(day_reg);
            csm_pkg::FLD_MONTH:   cur_value = 8'(month_reg);
            csm_pkg::FLD_WEEKDAY: cur_value = 8'(wday_reg);
            default:              cur_value = 8'd0;
        endcase
    end

    csm_cmp u_cmp (
        .a   (rd_data),
        .b   (cur_value),
        .res (cmp)
    );

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= csm_pkg::ST_IDLE;
            phase_reg      <= csm_pkg::PH_ENTRY;
            ptr_reg        <= '0;
            fidx_reg       <= '0;
            mismatch_reg   <= 1'b0;
            count_reg      <= '0;
            dropped_reg    <= 1'b0;
            pend_valid_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            phase_reg      <= phase_next;
            ptr_reg        <= ptr_next;
            fidx_reg       <= fidx_next;
            mismatch_reg   <= mismatch_next;
            count_reg      <= count_next;
            dropped_reg    <= dropped_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        pend_off_reg <= pend_off_next;
        minute_reg   <= minute_next;
        hour_reg     <= hour_next;
        day_reg      <= day_next;
        month_reg    <= month_next;
        wday_reg     <= wday_next;
    end

    assign busy    = (state_reg != csm_pkg::ST_IDLE);
    assign rd_addr = ptr_reg[csm_pkg::ADDR_W-1:0];

    // Sequence the scan one store byte at a time
    always_comb begin
        logic field_done;

        state_next      = state_reg;
        phase_next      = phase_reg;
        ptr_next        = ptr_reg;
        fidx_next       = fidx_reg;
        mismatch_next   = mismatch_reg;
        count_next      = count_reg;
        dropped_next    = dropped_reg;
        pend_valid_next = pend_valid_reg;
        pend_off_next   = pend_off_reg;
        minute_next     = minute_reg;
        hour_next       = hour_reg;
        day_next        = day_reg;
        month_next      = month_reg;
        wday_next       = wday_reg;
        rd_en           = 1'b0;
        push            = '0;
        field_done      = 1'b0;

        case (state_reg)
            csm_pkg::ST_IDLE: begin
                if (start) begin
                    minute_next     = tick.minute;
                    hour_next       = tick.hour;
                    day_next        = tick.day_of_month;
                    month_next      = tick.month;
                    wday_next       = tick.weekday;
                    ptr_next        = '0;
                    phase_next      = csm_pkg::PH_ENTRY;
                    count_next      = '0;
                    dropped_next    = 1'b0;
                    pend_valid_next = 1'b0;
                    mismatch_next   = 1'b0;
                    state_next      = csm_pkg::ST_READ;
                end
            end

            csm_pkg::ST_READ: begin
                // End the scan when the pointer runs off the store
                if (ptr_reg >= csm_pkg::PTR_W'(csm_pkg::STORE_DEPTH)) begin
                    state_next = csm_pkg::ST_FLUSH;
                end else begin
                    rd_en      = 1'b1;
                    state_next = csm_pkg::ST_EVAL;
                end
            end

            csm_pkg::ST_EVAL: begin
                state_next = csm_pkg::ST_READ;
                case (phase_reg)
                    csm_pkg::PH_ENTRY: begin
                        // Peek the entry head; reread it as the first field
                        if (rd_data == csm_pkg::MARK_END) begin
                            state_next = csm_pkg::ST_FLUSH;
                        end else begin
                            mismatch_next = 1'b0;
                            fidx_next     = '0;
                            phase_next    = csm_pkg::PH_HEAD;
                        end
                    end
                    csm_pkg::PH_HEAD: begin
                        ptr_next = ptr_reg + 1'b1;
                        if (rd_data == csm_pkg::MARK_ANY) begin
                            field_done = 1'b1;
                        end else if (rd_data == csm_pkg::MARK_LIST) begin
                            phase_next = csm_pkg::PH_LIST;
                        end else if (rd_data == csm_pkg::MARK_RANGE) begin
                            phase_next = csm_pkg::PH_RANGE_LO;
                        end else begin
                            if (!cmp.eq) begin
                                mismatch_next = 1'b1;
                            end
                            field_done = 1'b1;
                        end
                    end
                    csm_pkg::PH_LIST: begin
                        ptr_next = ptr_reg + 1'b1;
                        if (rd_data == csm_pkg::MARK_LIST) begin
                            mismatch_next = 1'b1;
                            field_done    = 1'b1;
                        end else if (cmp.eq) begin
                            phase_next = csm_pkg::PH_LIST_SKIP;
                        end
                    end
                    csm_pkg::PH_LIST_SKIP: begin
                        ptr_next = ptr_reg + 1'b1;
                        if (rd_data == csm_pkg::MARK_LIST) begin
                            field_done = 1'b1;
                        end
                    end
                    csm_pkg::PH_RANGE_LO: begin
                        ptr_next   = ptr_reg + 1'b1;
                        phase_next = csm_pkg::PH_RANGE_HI;
                        if (cmp.gt) begin
                            mismatch_next = 1'b1;
                        end
                    end
                    csm_pkg::PH_RANGE_HI: begin
                        ptr_next = ptr_reg + 1'b1;
                        if (cmp.lt) begin
                            mismatch_next = 1'b1;
                        end
                        field_done = 1'b1;
                    end
                    csm_pkg::PH_CMD: begin
                        ptr_next = ptr_reg + 1'b1;
                        if (rd_data == csm_pkg::CMD_END) begin
                            phase_next = csm_pkg::PH_ENTRY;
                        end
                    end
                    default: begin
                        state_next = csm_pkg::ST_FLUSH;
                    end
                endcase

                // Advance to the next field or settle the entry
                if (field_done) begin
                    if (fidx_reg == csm_pkg::FLD_WEEKDAY) begin
                        state_next = csm_pkg::ST_RECORD;
                    end else begin
                        fidx_next  = fidx_reg + 1'b1;
                        phase_next = csm_pkg::PH_HEAD;
                    end
                end
            end

            csm_pkg::ST_RECORD: begin
                // Hold a match back until the next one shows it is not the last
                if (mismatch_reg) begin
                    phase_next = csm_pkg::PH_CMD;
                    state_next = csm_pkg::ST_READ;
                end else if (count_reg < csm_pkg::CNT_W'(csm_pkg::MAX_MATCHES)) begin
                    if (!pend_valid_reg || out_free) begin
                        push.valid               = pend_valid_reg;
                        push.data.command_offset = pend_off_reg;
                        push.data.matched        = 1'b1;
                        push.data.overflow       = 1'b0;
                        push.data.last           = 1'b0;
                        pend_valid_next          = 1'b1;
                        pend_off_next            = csm_pkg::OFFSET_W'(ptr_reg);
                        count_next               = count_reg + 1'b1;
                        phase_next               = csm_pkg::PH_CMD;
                        state_next               = csm_pkg::ST_READ;
                    end
                end else begin
                    dropped_next = 1'b1;
                    phase_next   = csm_pkg::PH_CMD;
                    state_next   = csm_pkg::ST_READ;
                end
            end

            csm_pkg::ST_FLUSH: begin
                // Deliver the final result, or the no-match result
                if (out_free) begin
                    push.valid               = 1'b1;
                    push.data.command_offset = pend_valid_reg ? pend_off_reg : '0;
                    push.data.matched        = pend_valid_reg;
                    push.data.overflow       = dropped_reg & pend_valid_reg;
                    push.data.last           = 1'b1;
                    pend_valid_next          = 1'b0;
                    state_next               = csm_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next = csm_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

### rtl/cron_schedule_matcher.sv
`timescale 1ns / 1ps

// Schedule matcher for compiled cron entries held in a 1024-byte store.
// Input channel (s_valid/s_ready/s_data): a request with action clear writes
// store_byte at store_addr; a write leaves s_ready high, so writes can follow
// each other every cycle while no tick is walking. A request with action set
// is a minute tick: the store is walked from offset 0 and every entry whose
// minute, hour, day, month and weekday fields all match yields one result.
// Result channel (m_valid/m_ready/m_data): command_offset of each matching
// entry in store order, matched set, last set on the final result. With no
// match one result with matched clear and last set is given. Beyond 16
// matches the rest are dropped and overflow is set on the final result.
// A tick holds s_ready low until its final result is in the output register.
// Each store byte gets a registered read from the store, then a pass through
// the shared compare unit. An entry head is read twice (end marker check,
// then first field); each entry settles in RECORD, and the end marker or the
// end of the store leads to FLUSH, which delivers the final result. Each
// result waits in one output register; a stalled m_ready halts the walk when
// the next result is due, without losing any state.
// Reset (aresetn low, synchronous) idles the sequencer and clears m_valid;
// the store is not cleared and must be written before a tick reads it.
module cron_schedule_matcher (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  csm_pkg::csm_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output csm_pkg::csm_out_t m_data
);

    logic                       busy;
    logic                       accept;
    logic                       wr_en;
    logic                       start;
    logic                       rd_en;
    logic [csm_pkg::ADDR_W-1:0] rd_addr;
    logic [7:0]                 rd_data;
    logic                       out_free;
    csm_pkg::csm_push_t         push;

    logic                       m_valid_reg, m_valid_next;
    csm_pkg::csm_out_t          m_data_reg;

    // Decode the request
    assign s_ready = !busy;
    assign accept  = s_valid && s_ready;
    assign wr_en   = accept && (s_data.action == csm_pkg::ACT_WRITE)
                     && (32'(s_data.store_addr) < csm_pkg::STORE_DEPTH);
    assign start   = accept && (s_data.action == csm_pkg::ACT_TICK);

    csm_store u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (csm_pkg::ADDR_W'(s_data.store_addr)),
        .wr_data (s_data.store_byte),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    csm_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (start),
        .tick     (s_data),
        .busy     (busy),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data),
        .out_free (out_free),
        .push     (push)
    );

    // Output register
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (push.valid) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.valid) begin
            m_data_reg <= push.data;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
